>>> rtl/lsbsd_pkg.sv
// Types and constants for the LSB stego stream decoder.
// No dependencies; imported by every module of the block.
package lsbsd_pkg;

    typedef struct packed {
        logic [7:0] image_byte;
        logic       start_of_image;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
        logic        is_last;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  header_skip;
        logic [2:0]  magic_length;
        logic [31:0] magic_bytes;
        logic [7:0]  max_ext_length;
    } t_cfg;

    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_SKIP    = 7'b0000010,
        PH_MAGIC   = 7'b0000100,
        PH_EXTLEN  = 7'b0001000,
        PH_EXTCHAR = 7'b0010000,
        PH_SIZE    = 7'b0100000,
        PH_DATA    = 7'b1000000
    } t_phase;

    localparam logic [2:0] KIND_MAGIC_OK       = 3'd0;
    localparam logic [2:0] KIND_MAGIC_MISMATCH = 3'd1;
    localparam logic [2:0] KIND_EXT_LENGTH     = 3'd2;
    localparam logic [2:0] KIND_EXT_CHAR       = 3'd3;
    localparam logic [2:0] KIND_FILE_SIZE      = 3'd4;
    localparam logic [2:0] KIND_DATA           = 3'd5;
    localparam logic [2:0] KIND_EXT_TOO_LONG   = 3'd6;

    localparam logic [1:0] CFG_HEADER_SKIP    = 2'd0;
    localparam logic [1:0] CFG_MAGIC_LENGTH   = 2'd1;
    localparam logic [1:0] CFG_MAGIC_BYTES    = 2'd2;
    localparam logic [1:0] CFG_MAX_EXT_LENGTH = 2'd3;

    localparam logic [7:0]  RST_HEADER_SKIP    = 8'd54;
    localparam logic [2:0]  RST_MAGIC_LENGTH   = 3'd2;
    localparam logic [31:0] RST_MAGIC_BYTES    = 32'h0000_2A23;
    localparam logic [7:0]  RST_MAX_EXT_LENGTH = 8'd8;
    localparam logic [2:0]  MAX_MAGIC_LENGTH   = 3'd4;

    localparam logic [5:0] CHAR_BITS = 6'd8;
    localparam logic [5:0] WORD_BITS = 6'd32;

endpackage

>>> rtl/lsbsd_cfg.sv
// Configuration register file of the LSB stego stream decoder.
// Depends on lsbsd_pkg.
module lsbsd_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    output lsbsd_pkg::t_cfg   o_cfg
);
    import lsbsd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_skip    <= RST_HEADER_SKIP;
            r_cfg.magic_length   <= RST_MAGIC_LENGTH;
            r_cfg.magic_bytes    <= RST_MAGIC_BYTES;
            r_cfg.max_ext_length <= RST_MAX_EXT_LENGTH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HEADER_SKIP:    r_cfg.header_skip    <= i_cfg_data[7:0];
                CFG_MAGIC_LENGTH:   r_cfg.magic_length   <= i_cfg_data[2:0];
                CFG_MAGIC_BYTES:    r_cfg.magic_bytes    <= i_cfg_data;
                CFG_MAX_EXT_LENGTH: r_cfg.max_ext_length <= i_cfg_data[7:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/lsbsd_decode.sv
// Decode state and single-step next-state logic: skip, bit gather, field sequencing.
// Depends on lsbsd_pkg.
module lsbsd_decode (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lsbsd_pkg::t_cfg        i_cfg,
    input  logic                   i_step,
    input  lsbsd_pkg::t_in_item    i_item,
    output logic                   o_emit,
    output lsbsd_pkg::t_out_item   o_result
);
    import lsbsd_pkg::*;

    t_phase      r_phase,      n_phase;
    logic [7:0]  r_skip_count, n_skip_count;
    logic [4:0]  r_bit_index,  n_bit_index;
    logic [31:0] r_gather,     n_gather;
    logic [31:0] r_field,      n_field;
    logic [2:0]  r_magic_index, n_magic_index;

    always_comb begin
        logic [2:0]  mlen;
        logic [5:0]  width;
        logic [31:0] shifted;
        logic [31:0] val;
        logic [7:0]  exp_byte;
        logic        go;

        n_phase       = r_phase;
        n_skip_count  = r_skip_count;
        n_bit_index   = r_bit_index;
        n_gather      = r_gather;
        n_field       = r_field;
        n_magic_index = r_magic_index;
        o_emit        = 1'b0;
        o_result      = '0;
        val           = '0;
        exp_byte      = '0;
        shifted       = '0;
        go            = 1'b1;
        mlen  = (i_cfg.magic_length > MAX_MAGIC_LENGTH) ? MAX_MAGIC_LENGTH
                                                        : i_cfg.magic_length;

        if (i_item.start_of_image) begin
            n_phase       = PH_SKIP;
            n_skip_count  = '0;
            n_bit_index   = '0;
            n_gather      = '0;
            n_field       = '0;
            n_magic_index = '0;
        end

        if (n_phase == PH_IDLE) begin
            go = 1'b0;
        end else if (n_phase == PH_SKIP) begin
            if (n_skip_count < i_cfg.header_skip) begin
                n_skip_count = n_skip_count + 8'd1;
                go = 1'b0;
            end else if (mlen == 3'd0) begin
                n_phase  = PH_EXTLEN;
                o_emit   = 1'b1;
                o_result = '{kind: KIND_MAGIC_OK, value: '0, is_last: 1'b0};
            end else begin
                n_phase = PH_MAGIC;
            end
        end

        width = (n_phase == PH_EXTLEN || n_phase == PH_SIZE) ? WORD_BITS : CHAR_BITS;

        if (go) begin
            shifted = n_gather | ({31'd0, i_item.image_byte[0]} << n_bit_index);
            if (({1'b0, n_bit_index} + 6'd1) < width) begin
                n_bit_index = n_bit_index + 5'd1;
                n_gather    = shifted;
            end else begin
                val         = shifted;
                n_gather    = '0;
                n_bit_index = '0;
                case (n_phase)
                    PH_MAGIC: begin
                        exp_byte = i_cfg.magic_bytes[{n_magic_index[1:0], 3'b000} +: 8];
                        if (val != {24'd0, exp_byte}) begin
                            n_field = 32'd1;
                        end
                        n_magic_index = n_magic_index + 3'd1;
                        if (n_magic_index >= mlen) begin
                            o_emit = 1'b1;
                            if (n_field != '0) begin
                                n_phase  = PH_IDLE;
                                o_result = '{kind: KIND_MAGIC_MISMATCH, value: '0,
                                             is_last: 1'b1};
                            end else begin
                                n_field  = '0;
                                n_phase  = PH_EXTLEN;
                                o_result = '{kind: KIND_MAGIC_OK, value: '0,
                                             is_last: 1'b0};
                            end
                        end
                    end
                    PH_EXTLEN: begin
                        if (val[31]) begin
                            val = '0;
                        end
                        o_emit = 1'b1;
                        if (val > {24'd0, i_cfg.max_ext_length}) begin
                            n_phase  = PH_IDLE;
                            o_result = '{kind: KIND_EXT_TOO_LONG, value: '0,
                                         is_last: 1'b1};
                        end else begin
                            n_field  = val;
                            n_phase  = (val != '0) ? PH_EXTCHAR : PH_SIZE;
                            o_result = '{kind: KIND_EXT_LENGTH, value: val,
                                         is_last: 1'b0};
                        end
                    end
                    PH_EXTCHAR: begin
                        n_field = n_field - 32'd1;
                        if (n_field == '0) begin
                            n_phase = PH_SIZE;
                        end
                        o_emit   = 1'b1;
                        o_result = '{kind: KIND_EXT_CHAR, value: val, is_last: 1'b0};
                    end
                    PH_SIZE: begin
                        if (val[31]) begin
                            val = '0;
                        end
                        n_field = val;
                        o_emit  = 1'b1;
                        if (val == '0) begin
                            n_phase  = PH_IDLE;
                            o_result = '{kind: KIND_FILE_SIZE, value: '0, is_last: 1'b1};
                        end else begin
                            n_phase  = PH_DATA;
                            o_result = '{kind: KIND_FILE_SIZE, value: val, is_last: 1'b0};
                        end
                    end
                    PH_DATA: begin
                        n_field = n_field - 32'd1;
                        o_emit  = 1'b1;
                        if (n_field == '0) begin
                            n_phase  = PH_IDLE;
                            o_result = '{kind: KIND_DATA, value: val, is_last: 1'b1};
                        end else begin
                            o_result = '{kind: KIND_DATA, value: val, is_last: 1'b0};
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_skip_count  <= '0;
            r_bit_index   <= '0;
            r_gather      <= '0;
            r_field       <= '0;
            r_magic_index <= '0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_skip_count  <= n_skip_count;
            r_bit_index   <= n_bit_index;
            r_gather      <= n_gather;
            r_field       <= n_field;
            r_magic_index <= n_magic_index;
        end
    end

endmodule

>>> rtl/lsb_stego_stream_decoder_unit.sv
// LSB stego stream decoder: how to use it
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one image file byte
//   per beat, with start_of_image set on the first byte of each file.
//   Output channel (o_out_valid / i_out_ready / o_out_data) gives at most one
//   tagged result per input beat: kind, value, is_last.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (0 header_skip, 1 magic_length, 2 magic_bytes, 3 max_ext_length); write
//   only while no beat is in flight.
// Pipeline: an accepted input beat is held in the input register, decoded by the
//   combinational decode logic, and its result stored in the result register.
//   Throughput: one input beat per cycle while the receiver does not stall.
// Reset (i_rst_n low, synchronous): registers return to their defaults, both
//   pipeline registers empty, decoder idle until a byte with start_of_image.
// Receiver stall: the result register holds; the input register still takes
//   one beat, then o_in_ready drops until the result is taken.
// Depends on lsbsd_pkg, lsbsd_cfg, lsbsd_decode.
module lsb_stego_stream_decoder_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  lsbsd_pkg::t_in_item    i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output lsbsd_pkg::t_out_item   o_out_data,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_index,
    input  logic [31:0]            i_cfg_data
);
    import lsbsd_pkg::*;

    t_cfg       w_cfg;
    logic       w_advance;
    logic       w_emit;
    t_out_item  w_result;

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item;

    lsbsd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    lsbsd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_step   (w_advance),
        .i_item   (r_in_item),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !w_advance)
        else $error("decode advanced into a stalled result register");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.kind <= KIND_EXT_TOO_LONG))
        else $error("result kind out of range");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.kind == KIND_MAGIC_OK ||
                         o_out_data.kind == KIND_MAGIC_MISMATCH ||
                         o_out_data.kind == KIND_EXT_TOO_LONG))
        |-> (o_out_data.value == '0))
        else $error("status result carries a nonzero value");

    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.kind == KIND_MAGIC_MISMATCH ||
                         o_out_data.kind == KIND_EXT_TOO_LONG))
        |-> o_out_data.is_last)
        else $error("error result not marked last");
`endif

endmodule
